/* hw/rtl/dtfp_pkg.sv */
`timescale 1ns / 1ps
// dtfp_pkg: shared types, character codes and the power-of-ten table
// for the decimal text to fixed point parser; no dependencies
package dtfp_pkg;

   localparam int CHAR_W              = 8;
   localparam int MANT_W              = 64;
   localparam int FDIG_W              = 5;
   localparam int VAL_W               = 48;
   localparam int QUO_W               = VAL_W + 1;
   localparam int FRAC_BITS_DEF       = 16;
   localparam int MAX_FRAC_DIGITS_DEF = 18;
   localparam int POW10_MAX           = 19;

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [3:0]        DIGIT_MASK = 4'hF;

   localparam logic [QUO_W-1:0] MAG_LIMIT = QUO_W'(1) << (VAL_W - 1);

   localparam logic [MANT_W-1:0] POW10 [0:POW10_MAX] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
      64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000,
      64'd10000000000, 64'd100000000000, 64'd1000000000000,
      64'd10000000000000, 64'd100000000000000, 64'd1000000000000000,
      64'd10000000000000000, 64'd100000000000000000,
      64'd1000000000000000000, 64'd10000000000000000000
   };

   function automatic logic [MANT_W-1:0] pow10(input logic [FDIG_W-1:0] k);
      logic [FDIG_W-1:0] idx;
      idx = (k > FDIG_W'(POW10_MAX)) ? FDIG_W'(POW10_MAX) : k;
      return POW10[idx];
   endfunction

   typedef struct packed {
      logic accept;
      logic start_div;
      logic step_div;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_term;
   } sts_type;

endpackage

/* hw/rtl/dtfp_if.sv */
`timescale 1ns / 1ps
// dtfp_if: valid/ready channels for character beats and result beats
// depends on dtfp_pkg
interface dtfp_req_if;
   logic                         valid;
   logic                         ready;
   logic [dtfp_pkg::CHAR_W-1:0]  char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface dtfp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [dtfp_pkg::VAL_W-1:0]  fixed_value;
   logic                               overflow;

   modport source (output valid, output fixed_value, output overflow, input ready);
   modport sink   (input valid, input fixed_value, input overflow, output ready);
endinterface

/* hw/rtl/dtfp_datapath.sv */
`timescale 1ns / 1ps
// dtfp_datapath: parse registers, bit-serial restoring divider and result register
// depends on dtfp_pkg; driven by dtfp_ctrl commands
module dtfp_datapath #(
   parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dtfp_pkg::cmd_type                 cmd,
   output dtfp_pkg::sts_type                 sts,
   input  logic [dtfp_pkg::CHAR_W-1:0]       char_code,
   output logic signed [dtfp_pkg::VAL_W-1:0] fixed_value,
   output logic                              overflow
);

   localparam int MW = dtfp_pkg::MANT_W;
   localparam int FW = dtfp_pkg::FDIG_W;
   localparam int VW = dtfp_pkg::VAL_W;
   localparam int QW = dtfp_pkg::QUO_W;

   logic          start_ff, start_in;
   logic          neg_ff, neg_in;
   logic          point_ff, point_in;
   logic [MW-1:0] mant_ff, mant_in;
   logic [FW-1:0] fdig_ff, fdig_in;
   logic          movf_ff, movf_in;

   logic [MW-1:0] dvd_ff, dvd_in;
   logic [MW-1:0] dsr_ff, dsr_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          stk_ff, stk_in;
   logic          dneg_ff, dneg_in;
   logic          dmovf_ff, dmovf_in;

   logic [VW-1:0] val_ff, val_in;
   logic          ovf_ff, ovf_in;

   logic          is_digit, is_point, lead_minus, frac_full;
   logic [MW+3:0] mant_x10;
   logic [MW:0]   rem_sh, rem_sub;
   logic          ge;
   logic          big;

   // character classes
   always_comb begin
      is_digit   = char_code inside {[dtfp_pkg::CH_ZERO:dtfp_pkg::CH_NINE]};
      is_point   = (char_code == dtfp_pkg::CH_POINT);
      lead_minus = start_ff && (char_code == dtfp_pkg::CH_MINUS);
      frac_full  = point_ff && (fdig_ff >= FW'(MAX_FRAC_DIGITS));
      sts.is_term = !lead_minus && !is_digit && !is_point;
   end

   // mantissa * 10 + digit, shift and add
   assign mant_x10 = ({4'd0, mant_ff} << 3) + ({4'd0, mant_ff} << 1)
                   + (MW+4)'(char_code[3:0] & dtfp_pkg::DIGIT_MASK);

   always_comb begin
      start_in = start_ff;
      neg_in   = neg_ff;
      point_in = point_ff;
      mant_in  = mant_ff;
      fdig_in  = fdig_ff;
      movf_in  = movf_ff;
      if (cmd.accept) begin
         start_in = 1'b0;
         if (lead_minus) begin
            neg_in = 1'b1;
         end else if (is_digit) begin
            if (!frac_full) begin
               if (point_ff) begin
                  fdig_in = fdig_ff + FW'(1);
               end
               if (movf_ff || (mant_x10[MW+3:MW] != 4'd0)) begin
                  mant_in = '1;
                  movf_in = 1'b1;
               end else begin
                  mant_in = mant_x10[MW-1:0];
               end
            end
         end else if (is_point) begin
            point_in = 1'b1;
         end else begin
            // terminator: rearm
            start_in = 1'b1;
            neg_in   = 1'b0;
            point_in = 1'b0;
            mant_in  = '0;
            fdig_in  = '0;
            movf_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         neg_ff   <= 1'b0;
         point_ff <= 1'b0;
         mant_ff  <= '0;
         fdig_ff  <= '0;
         movf_ff  <= 1'b0;
      end else begin
         start_ff <= start_in;
         neg_ff   <= neg_in;
         point_ff <= point_in;
         mant_ff  <= mant_in;
         fdig_ff  <= fdig_in;
         movf_ff  <= movf_in;
      end
   end

   // one quotient bit per step over mantissa bits then FRAC_BITS zero bits
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[MW-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      ge      = (rem_sh >= {1'b0, dsr_ff});
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      stk_in   = stk_ff;
      dneg_in  = dneg_ff;
      dmovf_in = dmovf_ff;
      if (cmd.start_div) begin
         dvd_in   = mant_ff;
         dsr_in   = dtfp_pkg::pow10(fdig_ff);
         rem_in   = '0;
         quo_in   = '0;
         stk_in   = 1'b0;
         dneg_in  = neg_ff;
         dmovf_in = movf_ff;
      end else if (cmd.step_div) begin
         dvd_in = {dvd_ff[MW-2:0], 1'b0};
         rem_in = ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
         stk_in = stk_ff | quo_ff[QW-1];
      end
   end

   // saturation and sign
   always_comb begin
      big    = stk_ff || (quo_ff > dtfp_pkg::MAG_LIMIT);
      ovf_in = dmovf_ff;
      if (dneg_ff) begin
         if (big) begin
            val_in = dtfp_pkg::MAG_LIMIT[VW-1:0];
            ovf_in = 1'b1;
         end else begin
            val_in = VW'(0) - quo_ff[VW-1:0];
         end
      end else begin
         if (big || (quo_ff > (dtfp_pkg::MAG_LIMIT - QW'(1)))) begin
            val_in = VW'(dtfp_pkg::MAG_LIMIT - QW'(1));
            ovf_in = 1'b1;
         end else begin
            val_in = quo_ff[VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      dsr_ff   <= dsr_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      stk_ff   <= stk_in;
      dneg_ff  <= dneg_in;
      dmovf_ff <= dmovf_in;
      if (cmd.load_out) begin
         val_ff <= val_in;
         ovf_ff <= ovf_in;
      end
   end

   assign fixed_value = signed'(val_ff);
   assign overflow    = ovf_ff;

endmodule

/* hw/rtl/dtfp_ctrl.sv */
`timescale 1ns / 1ps
// dtfp_ctrl: sequencer for character beats, divider steps and result hand-off
// depends on dtfp_pkg
module dtfp_ctrl #(
   parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dtfp_pkg::sts_type sts,
   output dtfp_pkg::cmd_type cmd
);

   localparam int DIV_STEPS = dtfp_pkg::MANT_W + FRAC_BITS;
   localparam int CW        = $clog2(DIV_STEPS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          last_step;

   assign last_step = (cnt_ff == CW'(DIV_STEPS - 1));

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      cmd.accept    = req_valid && req_ready;
      cmd.start_div = cmd.accept && sts.is_term;
      cmd.step_div  = (state_ff == S_DIV);
      cmd.load_out  = (state_ff == S_LOAD) && (!rsp_valid_ff || rsp_ready);

      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start_div) begin
               state_in = S_DIV;
               cnt_in   = '0;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + CW'(1);
            if (last_step) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (cmd.load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/decimal_text_to_fixed_point.sv */
`timescale 1ns / 1ps
// decimal_text_to_fixed_point: ascii decimal number stream to signed fixed point
// depends on dtfp_pkg, dtfp_if, dtfp_ctrl, dtfp_datapath
//
//   channel   dir   handshake            payload
//   req_bus   in    valid / ready        char_code[7:0]
//   rsp_bus   out   valid / ready        fixed_value[47:0] signed, overflow
//
// digit, point and leading minus beats are accepted without leaving the idle state
// a terminating beat starts a 64 + FRAC_BITS step restoring divider, one
// quotient bit per cycle; req ready stays low through the divide and load
// states, longer if the previous result is still held
// the result register lets character beats continue while rsp is stalled
// synchronous active-high reset rearms the parser and empties rsp
module decimal_text_to_fixed_point #(
   parameter int FRAC_BITS       = dtfp_pkg::FRAC_BITS_DEF,
   parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dtfp_req_if.sink    req_bus,
   dtfp_rsp_if.source  rsp_bus
);

   dtfp_pkg::cmd_type cmd;
   dtfp_pkg::sts_type sts;

   dtfp_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dtfp_datapath #(
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .char_code   (req_bus.char_code),
      .fixed_value (rsp_bus.fixed_value),
      .overflow    (rsp_bus.overflow)
   );

endmodule

/* hw/rtl/dtfp_checker.sv */
`timescale 1ns / 1ps
// dtfp_checker: port-level checks for decimal_text_to_fixed_point
// depends on dtfp_pkg; bound to the top level below
module dtfp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [dtfp_pkg::CHAR_W-1:0]       req_char_code,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [dtfp_pkg::VAL_W-1:0] rsp_fixed_value,
   input logic                              rsp_overflow
);

   logic req_beat, body_char, term_char;

   assign req_beat  = req_valid && req_ready;
   assign body_char = ((req_char_code >= dtfp_pkg::CH_ZERO)
                       && (req_char_code <= dtfp_pkg::CH_NINE))
                      || (req_char_code == dtfp_pkg::CH_POINT);
   assign term_char = !body_char && (req_char_code != dtfp_pkg::CH_MINUS);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fixed_value)
                                  && $stable(rsp_overflow))
      else $error("rsp beat changed while stalled");

   a_body_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      req_beat && body_char |=> req_ready)
      else $error("digit or point beat blocked the input");

   a_term_drops_ready: assert property (@(posedge clock) disable iff (reset)
      req_beat && term_char |=> !req_ready)
      else $error("terminator did not start the divider");

   a_rsp_with_ready: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result shown while divider busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_char_code   (req_bus.char_code),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_fixed_value (rsp_bus.fixed_value),
   .rsp_overflow    (rsp_bus.overflow)
);
